// ----- design/longest_bounded_range_window_unit_macros.svh -----
// Assertion macros used by the checker file of the window unit.
// No dependencies; included by bare file name.
`ifndef LONGEST_BOUNDED_RANGE_WINDOW_UNIT_MACROS_SVH
`define LONGEST_BOUNDED_RANGE_WINDOW_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LBR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LBR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lbr_pkg.sv -----
// Shared types and constants of the longest bounded-range window unit.
// No dependencies.
package lbr_pkg;

  // Parameter defaults
  localparam int MAX_ITEMS_DEF  = 128;
  localparam int VALUE_BITS_DEF = 16;

  // Fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int RANGE_W     = 16;
  localparam int THRESH_W    = 17;
  localparam int LEN_W       = 8;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LIMIT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DROP_THRESHOLD = 1'd1;

  // Reset values and limits
  localparam logic [RANGE_W-1:0]  RANGE_RESET  = 16'd0;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd600;
  localparam int MIN_RUN = 2;
  localparam int LEN_MAX = 255;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_CMP,
    ST_PUSH,
    ST_SH_RD,
    ST_SH_CMP,
    ST_EMIT
  } lbr_state_t;

  // Commands to one index queue
  typedef struct packed {
    logic clear;
    logic push;
    logic pop_back;
    logic pop_front;
  } deque_cmd_t;

  // Status of one index queue
  typedef struct packed {
    logic nonempty;
  } deque_stat_t;

endpackage

// ----- design/lbr_in_if.sv -----
// Input channel of the window unit: one sample word per handshake.
// Depends on lbr_pkg.
interface lbr_in_if;
  logic                         valid;
  logic                         ready;
  logic [lbr_pkg::SAMPLE_W-1:0] sample;
  logic                         last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// ----- design/lbr_out_if.sv -----
// Result channel of the window unit: one result word per sequence.
// Depends on lbr_pkg.
interface lbr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [lbr_pkg::LEN_W-1:0] best_length;
  logic                      overflow;

  modport source (output valid, output found, output best_length, output overflow,
                  input ready);
  modport sink   (input valid, input found, input best_length, input overflow,
                  output ready);
endinterface

// ----- design/lbr_deque.sv -----
// Monotonic index queue held in a synchronous memory, with head and tail pointers.
// Entries pair a sample index with its value. Depends on lbr_pkg.
module lbr_deque #(
  parameter int MAX_ITEMS  = lbr_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = lbr_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lbr_pkg::deque_cmd_t           cmd,
  input  logic [$clog2(MAX_ITEMS)-1:0]  push_idx,
  input  logic [VALUE_BITS-1:0]         push_val,
  output lbr_pkg::deque_stat_t          stat,
  output logic [VALUE_BITS-1:0]         tail_val,
  output logic [$clog2(MAX_ITEMS)-1:0]  head_idx,
  output logic [VALUE_BITS-1:0]         head_val
);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int ENT_W = IDX_W + VALUE_BITS;

  logic [ENT_W-1:0]      mem [MAX_ITEMS];
  logic [CNT_W-1:0]      head;
  logic [CNT_W-1:0]      tail;
  logic [CNT_W-1:0]      tail_dec;
  logic [VALUE_BITS-1:0] tail_rd;
  logic [ENT_W-1:0]      head_rd;

  assign tail_dec = tail - CNT_W'(1);

  // Memory: one write port, registered reads at the back and the front
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail[IDX_W-1:0]] <= {push_idx, push_val};
    end
    tail_rd <= mem[tail_dec[IDX_W-1:0]][VALUE_BITS-1:0];
    head_rd <= mem[head[IDX_W-1:0]];
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (cmd.pop_back) begin
        tail <= tail_dec;
      end else if (cmd.push) begin
        tail <= tail + CNT_W'(1);
      end
      if (cmd.pop_front) begin
        head <= head + CNT_W'(1);
      end
    end
  end

  assign stat.nonempty = tail > head;
  assign tail_val      = tail_rd;
  assign head_idx      = head_rd[ENT_W-1:VALUE_BITS];
  assign head_val      = head_rd[VALUE_BITS-1:0];
endmodule

// ----- design/lbr_ctrl.sv -----
// Sequencer of the window unit: filters samples, trims and fills both queues,
// shrinks the window, tracks the best length and holds the result register.
// Depends on lbr_pkg, lbr_in_if, lbr_out_if.
module lbr_ctrl #(
  parameter int MAX_ITEMS  = lbr_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = lbr_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  lbr_in_if.sink                        sample_ch,
  lbr_out_if.source                     result_ch,
  input  logic [lbr_pkg::RANGE_W-1:0]   range_limit,
  input  logic [lbr_pkg::THRESH_W-1:0]  drop_threshold,
  output lbr_pkg::deque_cmd_t           min_cmd,
  output lbr_pkg::deque_cmd_t           max_cmd,
  output logic [$clog2(MAX_ITEMS)-1:0]  push_idx,
  output logic [VALUE_BITS-1:0]         push_val,
  input  lbr_pkg::deque_stat_t          min_stat,
  input  lbr_pkg::deque_stat_t          max_stat,
  input  logic [VALUE_BITS-1:0]         min_tail_val,
  input  logic [VALUE_BITS-1:0]         max_tail_val,
  input  logic [$clog2(MAX_ITEMS)-1:0]  min_head_idx,
  input  logic [VALUE_BITS-1:0]         min_head_val,
  input  logic [$clog2(MAX_ITEMS)-1:0]  max_head_idx,
  input  logic [VALUE_BITS-1:0]         max_head_val
);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  lbr_pkg::lbr_state_t state, state_next;

  logic [VALUE_BITS-1:0] v;
  logic                  last_q;
  logic [CNT_W-1:0]      kept;
  logic [CNT_W-1:0]      ws;
  logic [CNT_W-1:0]      best;
  logic                  ovf;
  logic                  min_done;
  logic                  max_done;
  logic                  out_valid;
  logic                  out_found;
  logic [lbr_pkg::LEN_W-1:0] out_len;
  logic                  out_ovf;

  logic                  accept;
  logic [VALUE_BITS-1:0] sample_v;
  logic                  keep;
  logic                  room;
  logic                  min_pop;
  logic                  max_pop;
  logic [VALUE_BITS-1:0] diff;
  logic                  too_wide;
  logic                  min_first;
  logic [CNT_W-1:0]      len;
  logic [CNT_W-1:0]      ws_jump;
  logic                  out_free;
  logic [lbr_pkg::LEN_W-1:0] best_sat;

  // Datapath conditions
  assign accept    = sample_ch.valid && sample_ch.ready;
  assign sample_v  = VALUE_BITS'(sample_ch.sample);
  assign keep      = 32'(sample_v) < 32'(drop_threshold);
  assign room      = kept < CNT_W'(MAX_ITEMS);
  assign min_pop   = (state == lbr_pkg::ST_POP_CMP) && !min_done && min_stat.nonempty &&
                     (min_tail_val >= v);
  assign max_pop   = (state == lbr_pkg::ST_POP_CMP) && !max_done && max_stat.nonempty &&
                     (max_tail_val <= v);
  assign diff      = max_head_val - min_head_val;
  assign too_wide  = 32'(diff) > 32'(range_limit);
  assign min_first = min_head_idx < max_head_idx;
  assign ws_jump   = (min_first ? CNT_W'(min_head_idx) : CNT_W'(max_head_idx)) + CNT_W'(1);
  assign len       = kept - ws + CNT_W'(1);
  assign out_free  = !out_valid || result_ch.ready;
  assign best_sat  = (32'(best) > 32'(lbr_pkg::LEN_MAX)) ?
                     lbr_pkg::LEN_W'(lbr_pkg::LEN_MAX) : lbr_pkg::LEN_W'(best);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lbr_pkg::ST_IDLE: begin
        if (accept) begin
          if (keep && room) begin
            state_next = lbr_pkg::ST_POP_RD;
          end else if (sample_ch.last) begin
            state_next = lbr_pkg::ST_EMIT;
          end
        end
      end
      lbr_pkg::ST_POP_RD:  state_next = lbr_pkg::ST_POP_CMP;
      lbr_pkg::ST_POP_CMP: begin
        state_next = (min_pop || max_pop) ? lbr_pkg::ST_POP_RD : lbr_pkg::ST_PUSH;
      end
      lbr_pkg::ST_PUSH:    state_next = lbr_pkg::ST_SH_RD;
      lbr_pkg::ST_SH_RD:   state_next = lbr_pkg::ST_SH_CMP;
      lbr_pkg::ST_SH_CMP: begin
        if (too_wide) begin
          state_next = lbr_pkg::ST_SH_RD;
        end else if (last_q) begin
          state_next = lbr_pkg::ST_EMIT;
        end else begin
          state_next = lbr_pkg::ST_IDLE;
        end
      end
      lbr_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = lbr_pkg::ST_IDLE;
        end
      end
      default: state_next = lbr_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and queue commands
  always_comb begin
    sample_ch.ready   = (state == lbr_pkg::ST_IDLE);
    min_cmd           = '0;
    max_cmd           = '0;
    min_cmd.pop_back  = min_pop;
    max_cmd.pop_back  = max_pop;
    case (state)
      lbr_pkg::ST_PUSH: begin
        min_cmd.push = 1'b1;
        max_cmd.push = 1'b1;
      end
      lbr_pkg::ST_SH_CMP: begin
        min_cmd.pop_front = too_wide && min_first;
        max_cmd.pop_front = too_wide && !min_first;
      end
      lbr_pkg::ST_EMIT: begin
        min_cmd.clear = out_free;
        max_cmd.clear = out_free;
      end
      default: ;
    endcase
  end

  assign push_idx = kept[IDX_W-1:0];
  assign push_val = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= '0;
      ws   <= '0;
      best <= '0;
      ovf  <= 1'b0;
    end else begin
      case (state)
        lbr_pkg::ST_IDLE: begin
          if (accept && keep && !room) begin
            ovf <= 1'b1;
          end
        end
        lbr_pkg::ST_SH_CMP: begin
          if (too_wide) begin
            ws <= ws_jump;
          end else begin
            if ((32'(len) >= 32'(lbr_pkg::MIN_RUN)) && (len > best)) begin
              best <= len;
            end
            kept <= kept + CNT_W'(1);
          end
        end
        lbr_pkg::ST_EMIT: begin
          if (out_free) begin
            kept <= '0;
            ws   <= '0;
            best <= '0;
            ovf  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Item word and trim flags
  always_ff @(posedge clk) begin
    if (accept) begin
      v        <= sample_v;
      last_q   <= sample_ch.last;
      min_done <= 1'b0;
      max_done <= 1'b0;
    end else if (state == lbr_pkg::ST_POP_CMP) begin
      if (!min_pop) begin
        min_done <= 1'b1;
      end
      if (!max_pop) begin
        max_done <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == lbr_pkg::ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == lbr_pkg::ST_EMIT) && out_free) begin
      out_found <= 32'(best) >= 32'(lbr_pkg::MIN_RUN);
      out_len   <= (32'(best) >= 32'(lbr_pkg::MIN_RUN)) ? best_sat : '0;
      out_ovf   <= ovf;
    end
  end

  assign result_ch.valid       = out_valid;
  assign result_ch.found       = out_found;
  assign result_ch.best_length = out_len;
  assign result_ch.overflow    = out_ovf;
endmodule

// ----- design/longest_bounded_range_window_unit.sv -----
// Longest bounded-range window: a dropped or overflowing word is taken while idle;
// a kept word passes rounds of read and compare that pop back entries (both queues
// popping together), a push, and rounds of read and compare that pop one front entry,
// as queue reads are registered. The last word loads the result register once free.
// Reset (synchronous, rst high) empties both queues and clears counters, range_limit
// to 0 and drop_threshold to 600; queue memory contents are not cleared.
module longest_bounded_range_window_unit #(
  parameter int MAX_ITEMS  = lbr_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = lbr_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  lbr_in_if.sink                           sample_ch,
  lbr_out_if.source                        result_ch,
  input  logic                             cfg_we,
  input  logic [lbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int IDX_W = $clog2(MAX_ITEMS);

  logic [lbr_pkg::RANGE_W-1:0]  range_limit;
  logic [lbr_pkg::THRESH_W-1:0] drop_threshold;

  lbr_pkg::deque_cmd_t  min_cmd, max_cmd;
  lbr_pkg::deque_stat_t min_stat, max_stat;
  logic [IDX_W-1:0]      push_idx;
  logic [VALUE_BITS-1:0] push_val;
  logic [IDX_W-1:0]      min_head_idx, max_head_idx;
  logic [VALUE_BITS-1:0] min_tail_val, max_tail_val, min_head_val, max_head_val;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit    <= lbr_pkg::RANGE_RESET;
      drop_threshold <= lbr_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lbr_pkg::REG_RANGE_LIMIT:    range_limit    <= cfg_data[lbr_pkg::RANGE_W-1:0];
        lbr_pkg::REG_DROP_THRESHOLD: drop_threshold <= cfg_data[lbr_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  lbr_ctrl #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .sample_ch      (sample_ch),
    .result_ch      (result_ch),
    .range_limit    (range_limit),
    .drop_threshold (drop_threshold),
    .min_cmd        (min_cmd),
    .max_cmd        (max_cmd),
    .push_idx       (push_idx),
    .push_val       (push_val),
    .min_stat       (min_stat),
    .max_stat       (max_stat),
    .min_tail_val   (min_tail_val),
    .max_tail_val   (max_tail_val),
    .min_head_idx   (min_head_idx),
    .min_head_val   (min_head_val),
    .max_head_idx   (max_head_idx),
    .max_head_val   (max_head_val)
  );

  // Queue of indices with increasing values (window minimum at the head)
  lbr_deque #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_min_q (
    .clk      (clk),
    .rst      (rst),
    .cmd      (min_cmd),
    .push_idx (push_idx),
    .push_val (push_val),
    .stat     (min_stat),
    .tail_val (min_tail_val),
    .head_idx (min_head_idx),
    .head_val (min_head_val)
  );

  // Queue of indices with decreasing values (window maximum at the head)
  lbr_deque #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_max_q (
    .clk      (clk),
    .rst      (rst),
    .cmd      (max_cmd),
    .push_idx (push_idx),
    .push_val (push_val),
    .stat     (max_stat),
    .tail_val (max_tail_val),
    .head_idx (max_head_idx),
    .head_val (max_head_val)
  );
endmodule

// ----- design/lbr_checker.sv -----
// Port-level checks of the window unit's result channel, bound to the top level.
// Depends on longest_bounded_range_window_unit_macros.svh and lbr_pkg.
`include "longest_bounded_range_window_unit_macros.svh"

module lbr_checker #(
  parameter int MAX_ITEMS = lbr_pkg::MAX_ITEMS_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      found,
  input logic [lbr_pkg::LEN_W-1:0] best_length,
  input logic                      overflow
);
  // A reported run exists exactly when the length is nonzero
  `LBR_ASSERT_IMPLY(a_found_len, clk, rst, out_valid, found == (best_length != '0), "found and best_length disagree")
  // A found run has at least two samples
  `LBR_ASSERT_IMPLY(a_min_run, clk, rst, out_valid && found, 32'(best_length) >= lbr_pkg::MIN_RUN, "run shorter than two")
  // A run never exceeds the store capacity
  `LBR_ASSERT_IMPLY(a_cap, clk, rst, out_valid, 32'(best_length) <= MAX_ITEMS, "run longer than capacity")
  // A stalled result word holds
  `LBR_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable({found, best_length, overflow}), "stalled result changed")
endmodule

bind longest_bounded_range_window_unit lbr_checker #(.MAX_ITEMS(MAX_ITEMS)) u_lbr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result_ch.valid),
  .out_ready   (result_ch.ready),
  .found       (result_ch.found),
  .best_length (result_ch.best_length),
  .overflow    (result_ch.overflow)
);
